// ===== rtl/core/spvs_pkg.sv =====
// ----------------------------------------------------------------------------
// Supply VID search package
// Widths, codes and the helper function that the search core files share.
// ----------------------------------------------------------------------------
package spvs_pkg;

   localparam int VID_W     = 8;
   localparam int READING_W = 12;
   localparam int TARGET_W  = 20;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;
   localparam int SUM_W     = 18;
   localparam int COUNT_W   = 7;
   localparam int DIVISOR_W = 6;
   localparam int NUM_W     = SUM_W + 8;
   localparam int MEAN_W    = 21;
   localparam int ERR_W     = 22;
   localparam int EST_W     = 14;
   localparam int DIVCNT_W  = 5;

   localparam int MAX_CHIPS = 64;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LAUNCH_VID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING    = 2'd3;

   // Request opcodes.
   localparam logic OP_START = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Search phases.
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_FIRST  = 2'd1;
   localparam logic [1:0] PH_SETTLE = 2'd2;
   localparam logic [1:0] PH_STEP   = 2'd3;

   localparam logic [READING_W-1:0] MIN_SEED = 12'd1000;
   localparam logic signed [ERR_W-1:0] ERR_TOL = 22'sd2816;
   localparam logic [MEAN_W-1:0] MEAN_FLOOR = 21'd256;
   // floor(a / 3) == (a * 43691) >> 17 for every a below 2**16.
   localparam logic [15:0] RECIP3 = 16'd43691;
   localparam int RECIP3_SHIFT = 17;

   typedef struct packed {
      logic accept_start;
      logic accept_read;
      logic load_div;
      logic div_step;
      logic eval;
      logic est;
      logic decide;
   } spvs_cmd_type;

   typedef struct packed {
      logic phase_idle;
      logic div_last;
   } spvs_status_type;

   function automatic logic [VID_W-1:0] clamp_vid(input logic signed [EST_W-1:0] v,
                                                  input logic [VID_W-1:0] lo,
                                                  input logic [VID_W-1:0] hi);
      logic signed [EST_W-1:0] lo_s;
      logic signed [EST_W-1:0] hi_s;
      lo_s = $signed({{(EST_W-VID_W){1'b0}}, lo});
      hi_s = $signed({{(EST_W-VID_W){1'b0}}, hi});
      if (v > hi_s) begin
         return hi;
      end else if (v < lo_s) begin
         return lo;
      end
      return v[VID_W-1:0];
   endfunction

endpackage

// ===== rtl/core/spvs_req_if.sv =====
// ----------------------------------------------------------------------------
// Search request channel
// Valid/ready channel that carries start items and chip readings.
// ----------------------------------------------------------------------------
interface spvs_req_if;
   logic valid;
   logic ready;
   logic opcode;
   logic [spvs_pkg::READING_W-1:0] reading_mv;
   logic round_last;

   modport source(output valid, output opcode, output reading_mv, output round_last,
                  input ready);
   modport sink(input valid, input opcode, input reading_mv, input round_last,
                output ready);
endinterface

// ===== rtl/core/spvs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Search response channel
// Valid/ready channel that carries VID updates and search status.
// ----------------------------------------------------------------------------
interface spvs_rsp_if;
   logic valid;
   logic ready;
   logic [spvs_pkg::VID_W-1:0] vid_code;
   logic ramp_from_start;
   logic search_done;
   logic search_failed;

   modport source(output valid, output vid_code, output ramp_from_start,
                  output search_done, output search_failed, input ready);
   modport sink(input valid, input vid_code, input ramp_from_start,
                input search_done, input search_failed, output ready);
endinterface

// ===== rtl/core/spvs_datapath.sv =====
// ----------------------------------------------------------------------------
// Supply VID search datapath
// Round accumulators, serial mean divider, error and estimate arithmetic,
// search state and the response register.
// ----------------------------------------------------------------------------
module spvs_datapath import spvs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_wdata,
   input  logic [READING_W-1:0]  reading_mv,
   input  spvs_cmd_type          cmd,
   output spvs_status_type       status,
   output logic [VID_W-1:0]      vid_code,
   output logic                  ramp_from_start,
   output logic                  search_done,
   output logic                  search_failed
);

   logic [VID_W-1:0]     launch_vid_ff;
   logic [TARGET_W-1:0]  target_ff;
   logic [VID_W-1:0]     floor_ff;
   logic [VID_W-1:0]     ceiling_ff;

   logic [1:0]              phase_ff, phase_in;
   logic [VID_W-1:0]        cur_vid_ff, cur_vid_in;
   logic signed [ERR_W-1:0] prev_err_ff, prev_err_in;
   logic [SUM_W-1:0]        sum_ff;
   logic [READING_W-1:0]    max_ff, min_ff;
   logic [COUNT_W-1:0]      count_ff, chip_pos_ff;

   logic [NUM_W-1:0]      quot_ff;
   logic [DIVISOR_W-1:0]  rem_ff, divisor_ff;
   logic [DIVCNT_W-1:0]   div_cnt_ff;

   logic [MEAN_W-1:0]        mean_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic [EST_W+16-1:0]      prod_ff;
   logic                     neg_ff;

   logic [VID_W-1:0] out_vid_in;
   logic             out_ramp_in, out_done_in, out_fail_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_vid_ff <= '0;
         target_ff     <= '0;
         floor_ff      <= '0;
         ceiling_ff    <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LAUNCH_VID: launch_vid_ff <= csr_wdata[VID_W-1:0];
            CSR_TARGET:     target_ff     <= csr_wdata[TARGET_W-1:0];
            CSR_FLOOR:      floor_ff      <= csr_wdata[VID_W-1:0];
            CSR_CEILING:    ceiling_ff    <= csr_wdata[VID_W-1:0];
            default: ;
         endcase
      end
   end

   // Round accumulators.
   logic [NUM_W-1:0] num;
   logic             small_round;
   always_comb begin
      num = {sum_ff - {{(SUM_W-READING_W){1'b0}}, max_ff}
                    - {{(SUM_W-READING_W){1'b0}}, min_ff}, 8'd0};
      small_round = (count_ff <= COUNT_W'(2));
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.accept_start || cmd.load_div) begin
         sum_ff      <= '0;
         max_ff      <= '0;
         min_ff      <= MIN_SEED;
         count_ff    <= '0;
         chip_pos_ff <= '0;
      end else if (cmd.accept_read && phase_ff != PH_IDLE
                   && chip_pos_ff < COUNT_W'(MAX_CHIPS)) begin
         chip_pos_ff <= chip_pos_ff + 1'b1;
         if (reading_mv != '0) begin
            sum_ff   <= sum_ff + {{(SUM_W-READING_W){1'b0}}, reading_mv};
            count_ff <= count_ff + 1'b1;
            if (reading_mv > max_ff) max_ff <= reading_mv;
            if (reading_mv < min_ff) min_ff <= reading_mv;
         end
      end
   end

   // Restoring divider: one quotient bit per cycle.
   logic [DIVISOR_W:0] rem_shift;
   logic               take;
   always_comb begin
      rem_shift = {rem_ff, quot_ff[NUM_W-1]};
      take      = rem_shift >= {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.load_div) begin
         quot_ff    <= small_round ? '0 : num;
         divisor_ff <= small_round ? DIVISOR_W'(1) : DIVISOR_W'(count_ff - COUNT_W'(2));
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= take ? DIVISOR_W'(rem_shift - {1'b0, divisor_ff})
                            : rem_shift[DIVISOR_W-1:0];
         quot_ff    <= {quot_ff[NUM_W-2:0], take};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // Error and estimate.
   logic signed [ERR_W:0] x;
   logic [ERR_W:0]        ax;
   always_comb begin
      x  = $signed({6'd0, launch_vid_ff, 9'd0} + {7'd0, launch_vid_ff, 8'd0})
           + $signed({err_ff[ERR_W-1], err_ff});
      ax = x[ERR_W] ? (ERR_W+1)'(-x) : x;
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         mean_ff <= quot_ff[MEAN_W-1:0];
         err_ff  <= $signed({1'b0, quot_ff[MEAN_W-1:0]}) - $signed({2'b00, target_ff});
      end
      if (cmd.est) begin
         prod_ff <= ax[ERR_W-1:8] * RECIP3;
         neg_ff  <= x[ERR_W];
      end
   end

   // Search decision.
   logic [EST_W-1:0]        q;
   logic signed [EST_W-1:0] est_v, vid_s, step_v;
   logic [VID_W-1:0]        step_vid;
   always_comb begin
      q        = EST_W'(prod_ff >> RECIP3_SHIFT);
      est_v    = neg_ff ? -$signed(q) : $signed(q);
      vid_s    = $signed({{(EST_W-VID_W){1'b0}}, cur_vid_ff});
      step_v   = err_ff < 0 ? vid_s - EST_W'(1) : vid_s + EST_W'(1);
      step_vid = clamp_vid(step_v, floor_ff, ceiling_ff);

      phase_in    = phase_ff;
      cur_vid_in  = cur_vid_ff;
      prev_err_in = prev_err_ff;
      out_vid_in  = vid_code;
      out_ramp_in = 1'b0;
      out_done_in = 1'b0;
      out_fail_in = 1'b0;

      if (cmd.accept_start) begin
         phase_in    = PH_FIRST;
         cur_vid_in  = launch_vid_ff;
         prev_err_in = '0;
         out_vid_in  = launch_vid_ff;
      end else if (cmd.decide) begin
         // Default outcome is one VID step in the direction of the error.
         phase_in    = PH_STEP;
         prev_err_in = err_ff;
         cur_vid_in  = step_vid;
         out_vid_in  = step_vid;
         if (mean_ff < MEAN_FLOOR) begin
            phase_in    = PH_IDLE;
            prev_err_in = prev_err_ff;
            cur_vid_in  = '0;
            out_vid_in  = '0;
            out_fail_in = 1'b1;
         end else if (phase_ff == PH_FIRST && (err_ff >= ERR_TOL || err_ff <= -ERR_TOL)) begin
            phase_in    = PH_SETTLE;
            cur_vid_in  = clamp_vid(est_v, floor_ff, ceiling_ff);
            out_vid_in  = cur_vid_in;
            out_ramp_in = 1'b1;
         end else if (phase_ff == PH_STEP) begin
            if (prev_err_ff < 0) begin
               if (err_ff >= 0 || cur_vid_ff == floor_ff) begin
                  phase_in    = PH_IDLE;
                  prev_err_in = prev_err_ff;
                  cur_vid_in  = (-prev_err_ff < err_ff && cur_vid_ff != '1)
                                ? cur_vid_ff + 1'b1 : cur_vid_ff;
                  out_vid_in  = cur_vid_in;
                  out_done_in = 1'b1;
               end
            end else if (err_ff <= 0 || cur_vid_ff == ceiling_ff) begin
               phase_in    = PH_IDLE;
               prev_err_in = prev_err_ff;
               cur_vid_in  = (prev_err_ff < -err_ff && cur_vid_ff != '0)
                             ? cur_vid_ff - 1'b1 : cur_vid_ff;
               out_vid_in  = cur_vid_in;
               out_done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         cur_vid_ff  <= '0;
         prev_err_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         cur_vid_ff  <= cur_vid_in;
         prev_err_ff <= prev_err_in;
      end
   end

   // Response register, loaded only when a result is produced.
   always_ff @(posedge clock) begin
      if (cmd.accept_start || cmd.decide) begin
         vid_code        <= out_vid_in;
         ramp_from_start <= out_ramp_in;
         search_done     <= out_done_in;
         search_failed   <= out_fail_in;
      end
   end

   always_comb begin
      status.phase_idle = (phase_ff == PH_IDLE);
      status.div_last   = (div_cnt_ff == DIVCNT_W'(NUM_W - 1));
   end

endmodule

// ===== rtl/core/spvs_controller.sv =====
// ----------------------------------------------------------------------------
// Supply VID search controller
// Sequences accept, divide, evaluate and decide steps and owns both
// handshakes.
// ----------------------------------------------------------------------------
module spvs_controller import spvs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_opcode,
   input  logic            req_round_last,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  spvs_status_type status,
   output spvs_cmd_type    cmd
);

   localparam logic [2:0] S_ACCEPT = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_EVAL   = 3'd3;
   localparam logic [2:0] S_EST    = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free, xfer;

   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == S_ACCEPT) && (req_opcode == OP_READ || slot_free);
      xfer      = req_valid && req_ready;

      cmd              = '0;
      cmd.accept_start = xfer && req_opcode == OP_START;
      cmd.accept_read  = xfer && req_opcode == OP_READ;
      cmd.load_div     = state_ff == S_LOAD;
      cmd.div_step     = state_ff == S_DIV;
      cmd.eval         = state_ff == S_EVAL;
      cmd.est          = state_ff == S_EST;
      cmd.decide       = state_ff == S_DECIDE && slot_free;

      state_in = state_ff;
      unique case (state_ff)
         S_ACCEPT: if (cmd.accept_read && req_round_last && !status.phase_idle) begin
            state_in = S_LOAD;
         end
         S_LOAD:   state_in = S_DIV;
         S_DIV:    if (status.div_last) begin
            state_in = S_EVAL;
         end
         S_EVAL:   state_in = S_EST;
         S_EST:    state_in = S_DECIDE;
         S_DECIDE: if (slot_free) begin
            state_in = S_ACCEPT;
         end
         default:  state_in = S_ACCEPT;
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.accept_start || cmd.decide;
      rsp_valid    = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/supply_vid_search_controller_core.sv =====
// ----------------------------------------------------------------------------
// Supply VID search controller core
// Searches for the supply VID code that brings the trimmed mean chip
// voltage to a programmed target.
// ----------------------------------------------------------------------------
// Usage: write the launch VID, target_voltage, vid_floor and vid_ceiling
// through the csr_ port while the block is idle. A start transfer on the
// request channel returns one response carrying the launch VID in the next
// cycle. Each reading transfer adds one chip reading to the current round;
// the reading flagged round_last closes the round and yields one response.
// Readings while no search runs are accepted and dropped.
// A round end passes through a load step, the bit-serial mean divider (one
// quotient bit per cycle), the error, the estimate multiply and the
// decision. Readings inside a round are taken every cycle. The response
// sits in an output register; while it waits, readings are still accepted,
// and only a start item or a finished round decision waits for the
// receiver to take it. Synchronous reset returns the registers to their
// reset values and leaves the block idle with no response pending.
// ----------------------------------------------------------------------------
module supply_vid_search_controller_core import spvs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   spvs_req_if.sink              req_chan,
   spvs_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_wdata
);

   spvs_cmd_type    cmd;
   spvs_status_type status;

   // The controller owns both handshakes and the step sequence.
   spvs_controller u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_opcode     (req_chan.opcode),
      .req_round_last (req_chan.round_last),
      .req_ready      (req_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .status         (status),
      .cmd            (cmd)
   );

   // The datapath holds the search state, the divider and the response.
   spvs_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .reading_mv      (req_chan.reading_mv),
      .cmd             (cmd),
      .status          (status),
      .vid_code        (rsp_chan.vid_code),
      .ramp_from_start (rsp_chan.ramp_from_start),
      .search_done     (rsp_chan.search_done),
      .search_failed   (rsp_chan.search_failed)
   );

   // A failed search always reports VID zero.
   a_fail_vid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.search_failed |-> rsp_chan.vid_code == '0)
      else $error("failed search reported a nonzero VID");

   // Ramp, done and failed are mutually exclusive.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> $onehot0({rsp_chan.ramp_from_start, rsp_chan.search_done,
                                   rsp_chan.search_failed}))
      else $error("response carries more than one status flag");

   // No request is taken while the divider runs.
   a_no_accept_in_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_chan.ready)
      else $error("request accepted during mean division");

   // A start transfer produces a response in the next cycle.
   a_start_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_start |=> rsp_chan.valid)
      else $error("start transfer produced no response");

endmodule

// ===== test/spvs_search_checker.sv =====
// ----------------------------------------------------------------------------
// Supply VID search checker
// Watches the request, response and register ports of the search core,
// predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module spvs_search_checker import spvs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   spvs_req_if                  req,
   spvs_rsp_if                  rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output int                   mismatch_count,
   output int                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [VID_W-1:0] vid_code;
      logic             ramp_from_start;
      logic             search_done;
      logic             search_failed;
   } vid_update_type;

   vid_update_type    vid_updates_due[$];

   logic [VID_W-1:0]  cfg_launch_vid;
   logic [TARGET_W-1:0] cfg_target;
   logic [VID_W-1:0]  cfg_floor;
   logic [VID_W-1:0]  cfg_ceiling;

   logic [1:0]        phase;
   int                vid_now;
   int                last_err;
   int                round_sum;
   int                round_max;
   int                round_min;
   int                round_count;
   int                chip_pos;

   function automatic int clamp_code(input int v);
      if (v > int'(cfg_ceiling)) return int'(cfg_ceiling);
      if (v < int'(cfg_floor)) return int'(cfg_floor);
      return v;
   endfunction

   function automatic vid_update_type make_update(input int vid, input logic ramp,
                                                  input logic done, input logic fail);
      vid_update_type u;
      u.vid_code = vid[VID_W-1:0];
      u.ramp_from_start = ramp;
      u.search_done = done;
      u.search_failed = fail;
      return u;
   endfunction

   task automatic clear_round();
      round_sum = 0;
      round_max = 0;
      round_min = int'(MIN_SEED);
      round_count = 0;
      chip_pos = 0;
   endtask

   task automatic step_code();
      vid_now = clamp_code(last_err < 0 ? vid_now - 1 : vid_now + 1);
      phase = PH_STEP;
      vid_updates_due.push_back(make_update(vid_now, 1'b0, 1'b0, 1'b0));
   endtask

   // Advances the search state by one request and queues the response it causes.
   task automatic predict_vid_update(input logic op, input int r, input logic last);
      longint num;
      int     mean;
      int     err;
      int     x;
      if (op == OP_START) begin
         clear_round();
         vid_now = int'(cfg_launch_vid);
         last_err = 0;
         phase = PH_FIRST;
         vid_updates_due.push_back(make_update(vid_now, 1'b0, 1'b0, 1'b0));
         return;
      end
      if (phase == PH_IDLE) return;
      if (chip_pos < MAX_CHIPS) begin
         chip_pos++;
         if (r > 0) begin
            round_sum += r;
            if (r > round_max) round_max = r;
            if (r < round_min) round_min = r;
            round_count++;
         end
      end
      if (!last) return;
      if (round_count <= 2) begin
         mean = 0;
      end else begin
         num = longint'(round_sum - round_max - round_min) << 8;
         mean = int'(num / (round_count - 2));
      end
      clear_round();
      err = mean - int'(cfg_target);
      if (mean < 256) begin
         phase = PH_IDLE;
         vid_now = 0;
         vid_updates_due.push_back(make_update(0, 1'b0, 1'b0, 1'b1));
         return;
      end
      if (phase == PH_FIRST) begin
         last_err = err;
         if (err >= 11 * 256 || err <= -11 * 256) begin
            // Division by 768 truncates toward zero, as the estimate requires.
            x = int'(cfg_launch_vid) * 768 + err;
            vid_now = clamp_code(x / 768);
            phase = PH_SETTLE;
            vid_updates_due.push_back(make_update(vid_now, 1'b1, 1'b0, 1'b0));
         end else begin
            step_code();
         end
         return;
      end
      if (phase == PH_SETTLE) begin
         last_err = err;
         step_code();
         return;
      end
      if (last_err < 0) begin
         if (err >= 0 || vid_now == int'(cfg_floor)) begin
            if (-last_err < err && vid_now < 255) vid_now++;
            phase = PH_IDLE;
            vid_updates_due.push_back(make_update(vid_now, 1'b0, 1'b1, 1'b0));
            return;
         end
      end else begin
         if (err <= 0 || vid_now == int'(cfg_ceiling)) begin
            if (last_err < -err && vid_now > 0) vid_now--;
            phase = PH_IDLE;
            vid_updates_due.push_back(make_update(vid_now, 1'b0, 1'b1, 1'b0));
            return;
         end
      end
      last_err = err;
      step_code();
   endtask

   always @(posedge clock) begin
      vid_update_type got;
      vid_update_type want;
      if (reset) begin
         cfg_launch_vid <= '0;
         cfg_target <= '0;
         cfg_floor <= '0;
         cfg_ceiling <= '1;
         phase = PH_IDLE;
         vid_now = 0;
         last_err = 0;
         clear_round();
         vid_updates_due.delete();
         mismatch_count <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = make_update(int'(rsp.vid_code), rsp.ramp_from_start,
                              rsp.search_done, rsp.search_failed);
            if (vid_updates_due.size() == 0) begin
               if (mismatch_count < 10)
                  $display("Unexpected response transfer: %p", got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = vid_updates_due.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display("Response mismatch: expected %p, actual %p", want, got);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req.valid && req.ready)
            predict_vid_update(req.opcode, int'(req.reading_mv), req.round_last);
         if (csr_we) begin
            case (csr_index)
               CSR_LAUNCH_VID: cfg_launch_vid <= csr_wdata[VID_W-1:0];
               CSR_TARGET:     cfg_target <= csr_wdata[TARGET_W-1:0];
               CSR_FLOOR:      cfg_floor <= csr_wdata[VID_W-1:0];
               CSR_CEILING:    cfg_ceiling <= csr_wdata[VID_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= vid_updates_due.size();
   end

endmodule

// ===== test/tb_supply_vid_search_controller_core.sv =====
// ----------------------------------------------------------------------------
// Supply VID search controller testbench
// Drives start items and measurement rounds under several register settings
// with random idling on both channels; a checker beside the core predicts
// and compares every response.
// ----------------------------------------------------------------------------
module tb_supply_vid_search_controller_core;
   import spvs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 40;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   int                   mismatch_count;
   int                   pending_count;
   int                   cycle_count = 0;
   int                   items_sent = 0;
   int                   rounds_sent = 0;
   int                   searches_started = 0;
   int                   settings_used = 0;
   int                   long_hold_left = 0;
   int                   rsp_gap_left = 0;

   spvs_req_if req_chan ();
   spvs_rsp_if rsp_chan ();

   supply_vid_search_controller_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   spvs_search_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .rsp            (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // The clock runs at a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_START;
      req_chan.reading_mv = '0;
      req_chan.round_last = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   // Most gaps are short, a few are long. The 0 outcome is common, which
   // gives stretches of back-to-back transfers.
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 85) return $urandom_range(1, 2);
      if (p < 97) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // The cycle counter doubles as the watchdog for a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver side. Ready gets exactly one assignment per clock edge. Once in
   // the run the receiver holds off for a long stretch while the sender keeps
   // going, so that a finished round decision must wait in the output
   // register and the core has to stall its request channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (cycle_count == 6000 || long_hold_left > 0) begin
         if (cycle_count == 6000) long_hold_left = 600;
         long_hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_gap_left = pick_gap();
      end
   end

   // Offers one request and returns at the edge of its transfer. Valid stays
   // high across back-to-back items, so it is only lowered for a real gap.
   task automatic send_request(input logic op, input int mv, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.reading_mv <= mv[READING_W-1:0];
      req_chan.round_last <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      if (op == OP_START) searches_started++;
      else if (last) rounds_sent++;
   endtask

   // Waits until every predicted response has been taken and then lets the
   // round-end latency pass, so that register writes only see an idle core.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers on consecutive edges. Write enable is raised
   // once and only lowered after the last one.
   task automatic program_search(input int launch_vid, input int target,
                                 input int floor_vid, input int ceiling_vid);
      csr_we <= 1'b1;
      csr_index <= CSR_LAUNCH_VID;
      csr_wdata <= CSR_DAT_W'(launch_vid);
      @(posedge clock);
      csr_index <= CSR_TARGET;
      csr_wdata <= CSR_DAT_W'(target);
      @(posedge clock);
      csr_index <= CSR_FLOOR;
      csr_wdata <= CSR_DAT_W'(floor_vid);
      @(posedge clock);
      csr_index <= CSR_CEILING;
      csr_wdata <= CSR_DAT_W'(ceiling_vid);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // Sends one measurement round of readings spread around a nominal value.
   // A few readings are absent, and rarely the round overruns the chip limit.
   task automatic send_round(input int nominal_mv, input int spread);
      int n;
      int mv;
      n = ($urandom_range(0, 29) == 0) ? $urandom_range(MAX_CHIPS, MAX_CHIPS + 8)
                                       : $urandom_range(3, 9);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) mv = 0;
         else if ($urandom_range(0, 39) == 0) mv = $urandom_range(0, 4095);
         else mv = nominal_mv + $urandom_range(0, 2 * spread) - spread;
         if (mv < 0) mv = 0;
         if (mv > 4095) mv = 4095;
         send_request(OP_READ, mv, i == n - 1);
      end
   endtask

   initial begin
      int target;
      int nominal;
      int floor_vid;
      int ceiling_vid;
      int p;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset register values: readings while idle
      // are dropped, a start answers with the launch VID, a round with too
      // few readings fails, and an all-high round still loses the 1000 mV seed.
      send_request(OP_READ, 4095, 1'b1);
      send_request(OP_READ, 0, 1'b0);
      send_request(OP_START, 0, 1'b0);
      send_request(OP_READ, 4095, 1'b0);
      send_request(OP_READ, 0, 1'b1);
      send_request(OP_START, 0, 1'b0);
      send_request(OP_READ, 4095, 1'b0);
      send_request(OP_READ, 4095, 1'b0);
      send_request(OP_READ, 4095, 1'b1);
      wait_idle();

      // Extreme registers: full-scale target with a high start, and a
      // ceiling below the floor so that the ceiling check wins.
      program_search(255, 1048320, 255, 0);
      send_request(OP_START, 0, 1'b0);
      send_request(OP_READ, 1, 1'b0);
      send_request(OP_READ, 1, 1'b0);
      send_request(OP_READ, 2, 1'b0);
      send_request(OP_READ, 3, 1'b1);
      send_request(OP_START, 0, 1'b0);
      send_request(OP_READ, 4095, 1'b0);
      send_request(OP_READ, 2048, 1'b0);
      send_request(OP_READ, 1024, 1'b0);
      send_request(OP_READ, 4095, 1'b1);
      send_request(OP_READ, 4095, 1'b1);
      wait_idle();

      // Random part: each setting runs a few searches of several rounds.
      // Readings mostly sit near the target, which keeps the search in its
      // stepping phase; wider spreads and noise reach the estimate and the
      // failure path.
      while (items_sent < 1600) begin
         p = $urandom_range(0, 9);
         if (p == 0) target = 0;
         else if (p == 1) target = 1048320;
         else target = $urandom_range(1, 4000) * 256 + $urandom_range(0, 255);
         floor_vid = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 120);
         ceiling_vid = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(130, 255);
         if ($urandom_range(0, 9) == 0) ceiling_vid = floor_vid + $urandom_range(0, 2);
         if (ceiling_vid > 255) ceiling_vid = 255;
         program_search($urandom_range(0, 255), target, floor_vid, ceiling_vid);
         nominal = target / 256;
         repeat ($urandom_range(2, 5)) begin
            send_request(OP_START, $urandom_range(0, 4095), $urandom_range(0, 1) == 1);
            repeat ($urandom_range(1, 7)) begin
               p = $urandom_range(0, 9);
               if (p < 6) send_round(nominal, $urandom_range(1, 4));
               else if (p < 9) send_round(nominal, $urandom_range(10, 40));
               else send_round($urandom_range(0, 4095), $urandom_range(0, 2000));
            end
            if ($urandom_range(0, 4) == 0)
               send_request(OP_READ, $urandom_range(0, 4095), $urandom_range(0, 1) == 1);
         end
         wait_idle();
      end

      $display("Sent %0d request transfers: %0d searches and %0d rounds over %0d settings.",
               items_sent, searches_started, rounds_sent, settings_used);
      $display("Mismatches counted: %0d.", mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== supply_vid_search_controller_core.f =====
rtl/core/spvs_pkg.sv
rtl/core/spvs_req_if.sv
rtl/core/spvs_rsp_if.sv
rtl/core/spvs_datapath.sv
rtl/core/spvs_controller.sv
rtl/core/supply_vid_search_controller_core.sv
test/spvs_search_checker.sv
test/tb_supply_vid_search_controller_core.sv
